// File: rtl/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared sizes, operation and status codes, and the command and status
// structs that join the multi-queue FIFO controller and datapath.
// ----------------------------------------------------------------------------
package mqf_pkg;

  // Block sizes.
  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 16;

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int QNUM_W  = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;

  // Derived widths for indexes, pointers and fill counts, and the store size.
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  // Wide enough to compare a queue number against the queue count.
  localparam int QCMP_W  = 9;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_VALID = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_TRUE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FALSE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // Register the accepted request word.
    logic commit;     // Update queue state, write or read the store.
    logic load_exec;  // Load the result register from the computed result.
    logic load_read;  // Load the result register from the store read data.
  } mqf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deq_hit;    // Held request is a dequeue from a non-empty queue.
  } mqf_stat_t;

endpackage

// File: rtl/mqf_ctrl.sv
// ----------------------------------------------------------------------------
// mqf_ctrl
// Controller for the multi-queue FIFO: sequences one request at a time
// through capture, execute and store read, and owns the result handshake.
// ----------------------------------------------------------------------------
module mqf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  mqf_pkg::mqf_stat_t stat,
  output mqf_pkg::mqf_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    cmd.load_exec = 1'b0;
    cmd.load_read = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.deq_hit) begin
          cmd.commit = 1'b1;
          state_next = S_READ;
        end else if (out_free) begin
          cmd.commit    = 1'b1;
          cmd.load_exec = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_exec || cmd.load_read) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/mqf_datapath.sv
// ----------------------------------------------------------------------------
// mqf_datapath
// Datapath for the multi-queue FIFO: request register, per-queue pointers
// and fill counts, the shared value store and the result register.
// ----------------------------------------------------------------------------
module mqf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic        [mqf_pkg::MODE_W-1:0]   mode,
  input  logic        [mqf_pkg::QNUM_W-1:0]   queue_number,
  input  logic signed [mqf_pkg::DATA_W-1:0]   data_value,
  input  mqf_pkg::mqf_cmd_t                   cmd,
  output mqf_pkg::mqf_stat_t                  stat,
  output logic        [mqf_pkg::STAT_W-1:0]   status,
  output logic signed [mqf_pkg::DATA_W-1:0]   result_value
);

  // Held request word.
  logic        [mqf_pkg::MODE_W-1:0] mode_r;
  logic        [mqf_pkg::QNUM_W-1:0] qnum_r;
  logic signed [mqf_pkg::DATA_W-1:0] data_r;

  // Per-queue state.
  logic [mqf_pkg::PTR_W-1:0] read_pointer  [mqf_pkg::NUM_QUEUES];
  logic [mqf_pkg::PTR_W-1:0] write_pointer [mqf_pkg::NUM_QUEUES];
  logic [mqf_pkg::CNT_W-1:0] fill_count    [mqf_pkg::NUM_QUEUES];

  // Value store with registered read.
  logic [mqf_pkg::DATA_W-1:0] queue_store [mqf_pkg::STORE_DEPTH];
  logic [mqf_pkg::DATA_W-1:0] rd_data;

  logic                         q_ok;
  logic [mqf_pkg::QIDX_W-1:0]   qi;
  logic [mqf_pkg::PTR_W-1:0]    rp;
  logic [mqf_pkg::PTR_W-1:0]    wp;
  logic [mqf_pkg::CNT_W-1:0]    cnt;
  logic                         q_empty;
  logic                         is_full;
  logic                         enq_hit;
  logic                         deq_hit;
  logic [mqf_pkg::STAT_W-1:0]   stat_calc;
  logic [mqf_pkg::DATA_W-1:0]   value_calc;

  // Capture the request when the controller accepts it.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode;
      qnum_r <= queue_number;
      data_r <= data_value;
    end
  end

  // Look up the addressed queue. An out-of-range queue acts empty and full.
  assign q_ok = {{(mqf_pkg::QCMP_W - mqf_pkg::QNUM_W){1'b0}}, qnum_r}
                < mqf_pkg::QCMP_W'(mqf_pkg::NUM_QUEUES);
  assign qi   = mqf_pkg::QIDX_W'(qnum_r);
  assign rp   = read_pointer[qi];
  assign wp   = write_pointer[qi];
  assign cnt  = fill_count[qi];

  assign q_empty  = !q_ok || (cnt == '0);
  assign is_full  = !q_ok || (cnt == mqf_pkg::CNT_W'(mqf_pkg::QUEUE_DEPTH));
  assign enq_hit  = (mode_r == mqf_pkg::MODE_ENQ) && !is_full;
  assign deq_hit  = (mode_r == mqf_pkg::MODE_DEQ) && !q_empty;
  assign stat.deq_hit = deq_hit;

  // Result for every case except a successful dequeue.
  always_comb begin
    stat_calc  = mqf_pkg::ST_VALID;
    value_calc = '0;
    case (mode_r)
      mqf_pkg::MODE_ENQ: begin
        if (is_full) begin
          stat_calc = mqf_pkg::ST_FULL;
        end else begin
          value_calc = data_r;
        end
      end
      mqf_pkg::MODE_DEQ: begin
        if (q_empty) begin
          stat_calc = mqf_pkg::ST_EMPTY;
        end
      end
      mqf_pkg::MODE_EMPTY: begin
        stat_calc = q_empty ? mqf_pkg::ST_TRUE : mqf_pkg::ST_FALSE;
      end
      default: begin
        stat_calc = mqf_pkg::ST_VALID;
      end
    endcase
  end

  // Pointers and fill counts. Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqf_pkg::NUM_QUEUES; i++) begin
        read_pointer[i]  <= '0;
        write_pointer[i] <= '0;
        fill_count[i]    <= '0;
      end
    end else if (cmd.commit) begin
      if (enq_hit) begin
        write_pointer[qi] <= (wp == mqf_pkg::PTR_W'(mqf_pkg::QUEUE_DEPTH - 1))
                             ? '0 : wp + 1'b1;
        fill_count[qi]    <= cnt + 1'b1;
      end else if (deq_hit) begin
        read_pointer[qi]  <= (rp == mqf_pkg::PTR_W'(mqf_pkg::QUEUE_DEPTH - 1))
                             ? '0 : rp + 1'b1;
        fill_count[qi]    <= cnt - 1'b1;
      end
    end
  end

  // Store write on enqueue, registered read on dequeue.
  always_ff @(posedge clk) begin
    if (cmd.commit && enq_hit) begin
      queue_store[{qi, wp}] <= data_r;
    end
    if (cmd.commit && deq_hit) begin
      rd_data <= queue_store[{qi, rp}];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_exec) begin
      status       <= stat_calc;
      result_value <= value_calc;
    end else if (cmd.load_read) begin
      status       <= mqf_pkg::ST_VALID;
      result_value <= rd_data;
    end
  end

endmodule

// File: rtl/multi_queue_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_fifo
// Set of independent ring-buffer FIFO queues of signed 32-bit values with
// enqueue, dequeue and empty-query requests, one result word per request.
// ----------------------------------------------------------------------------
// One request is in work at a time. A request word is taken in the idle
// state and executed against its queue's pointers and fill count in the
// execute state, where its result word is registered, or, for a dequeue
// that returns a value, in the store read state, because the shared
// value store is read through a registered port. A new request word is taken
// as soon as the previous result is registered, even if that result is still
// waiting on the result channel; a request stalls in execution or store
// read only while an undelivered result still occupies the output register.
// Enqueue into a full queue is dropped and reported as full; queue numbers
// at or above the queue count behave as queues that are both empty and full.
// ----------------------------------------------------------------------------
module multi_queue_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic        [mqf_pkg::MODE_W-1:0]   mode,
  input  logic        [mqf_pkg::QNUM_W-1:0]   queue_number,
  input  logic signed [mqf_pkg::DATA_W-1:0]   data_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic        [mqf_pkg::STAT_W-1:0]   status,
  output logic signed [mqf_pkg::DATA_W-1:0]   result_value
);

  mqf_pkg::mqf_cmd_t  cmd;
  mqf_pkg::mqf_stat_t stat;

  // Request sequencing and result handshake.
  mqf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Queue state, value store and result register.
  mqf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .queue_number (queue_number),
    .data_value   (data_value),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .result_value (result_value)
  );

endmodule

// File: test/multi_queue_fifo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_fifo_checker
// Watches both channels of the multi-queue FIFO, keeps its own copy of every
// queue, predicts the result word of each accepted request and compares the
// delivered result words against those predictions in order.
// ----------------------------------------------------------------------------
module multi_queue_fifo_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic        [mqf_pkg::MODE_W-1:0]   mode,
  input  logic        [mqf_pkg::QNUM_W-1:0]   queue_number,
  input  logic signed [mqf_pkg::DATA_W-1:0]   data_value,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  logic        [mqf_pkg::STAT_W-1:0]   status,
  input  logic signed [mqf_pkg::DATA_W-1:0]   result_value,
  output int                                  mismatch_total,
  output int                                  words_awaited,
  output int                                  words_checked,
  output int                                  full_drops,
  output int                                  empty_reads
);

  localparam int PAD_W = mqf_pkg::DATA_W - mqf_pkg::STAT_W;

  typedef struct packed {
    logic        [mqf_pkg::STAT_W-1:0] status;
    logic signed [mqf_pkg::DATA_W-1:0] value;
  } answer_t;

  // Shadow copy of the queues.
  logic signed [mqf_pkg::DATA_W-1:0] store_model [mqf_pkg::NUM_QUEUES][mqf_pkg::QUEUE_DEPTH];
  logic        [mqf_pkg::PTR_W-1:0]  head_slot   [mqf_pkg::NUM_QUEUES];
  logic        [mqf_pkg::PTR_W-1:0]  tail_slot   [mqf_pkg::NUM_QUEUES];
  logic        [mqf_pkg::CNT_W-1:0]  held_count  [mqf_pkg::NUM_QUEUES];

  // Result words predicted but not yet delivered, oldest first.
  answer_t awaited_answers [$];

  int mismatches = 0;
  int checked    = 0;
  int drops      = 0;
  int empties    = 0;

  // Ring pointers step modulo the queue depth.
  function automatic logic [mqf_pkg::PTR_W-1:0] next_slot(
      input logic [mqf_pkg::PTR_W-1:0] p);
    return (int'(p) == mqf_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // Applies one request to the shadow queues and returns its result word.
  function automatic answer_t apply_queue_op(
      input logic        [mqf_pkg::MODE_W-1:0] m,
      input logic        [mqf_pkg::QNUM_W-1:0] q,
      input logic signed [mqf_pkg::DATA_W-1:0] d);
    answer_t ans;
    logic    in_range;
    ans.status = mqf_pkg::ST_VALID;
    ans.value  = '0;
    in_range   = int'(q) < mqf_pkg::NUM_QUEUES;
    case (m)
      mqf_pkg::MODE_ENQ: begin
        if (!in_range || int'(held_count[q]) >= mqf_pkg::QUEUE_DEPTH) begin
          ans.status = mqf_pkg::ST_FULL;
        end else begin
          store_model[q][tail_slot[q]] = d;
          tail_slot[q]  = next_slot(tail_slot[q]);
          held_count[q] = held_count[q] + 1'b1;
          ans.value     = d;
        end
      end
      mqf_pkg::MODE_DEQ: begin
        if (!in_range || held_count[q] == '0) begin
          ans.status = mqf_pkg::ST_EMPTY;
        end else begin
          ans.value     = store_model[q][head_slot[q]];
          head_slot[q]  = next_slot(head_slot[q]);
          held_count[q] = held_count[q] - 1'b1;
        end
      end
      mqf_pkg::MODE_EMPTY: begin
        ans.status = (!in_range || held_count[q] == '0) ? mqf_pkg::ST_TRUE
                                                         : mqf_pkg::ST_FALSE;
      end
      // The reserved code does nothing and answers with a zero word.
      default: begin
      end
    endcase
    return ans;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string what,
                               input logic [mqf_pkg::DATA_W-1:0] want,
                               input logic [mqf_pkg::DATA_W-1:0] got);
    $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // Compare delivered words first, then record the request taken at this edge.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < mqf_pkg::NUM_QUEUES; i++) begin
        head_slot[i]  = '0;
        tail_slot[i]  = '0;
        held_count[i] = '0;
      end
      awaited_answers.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_answers.size() == 0) begin
          flag_mismatch("result word with no request outstanding",
                        {{PAD_W{1'b0}}, status}, result_value);
        end else begin
          want = awaited_answers.pop_front();
          checked++;
          if (want.status == mqf_pkg::ST_FULL) drops++;
          if (want.status == mqf_pkg::ST_EMPTY) empties++;
          if (status !== want.status) begin
            flag_mismatch("status", {{PAD_W{1'b0}}, want.status},
                          {{PAD_W{1'b0}}, status});
          end
          if (result_value !== want.value) begin
            flag_mismatch("result_value", want.value, result_value);
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_answers.push_back(apply_queue_op(mode, queue_number, data_value));
      end
    end
    mismatch_total <= mismatches;
    words_awaited  <= awaited_answers.size();
    words_checked  <= checked;
    full_drops     <= drops;
    empty_reads    <= empties;
  end

endmodule

// File: test/multi_queue_fifo_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_fifo_tb
// Drives request words into the multi-queue FIFO with random gaps and
// result-side stalls: a directed opening on the corner cases, then random
// traffic in phases that fill, drain and wrap the queues. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module multi_queue_fifo_tb;

  // Mode code with no operation behind it.
  localparam logic [mqf_pkg::MODE_W-1:0] MODE_RSVD = 2'd3;

  localparam int RANDOM_PHASES  = 21;
  localparam int PHASE_WORDS    = 50;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic                              clk          = 1'b0;
  logic                              rst          = 1'b1;
  logic                              req_valid    = 1'b0;
  logic                              req_stall;
  logic        [mqf_pkg::MODE_W-1:0] mode         = mqf_pkg::MODE_ENQ;
  logic        [mqf_pkg::QNUM_W-1:0] queue_number = '0;
  logic signed [mqf_pkg::DATA_W-1:0] data_value   = '0;
  logic                              rsp_valid;
  logic                              rsp_stall    = 1'b0;
  logic        [mqf_pkg::STAT_W-1:0] status;
  logic signed [mqf_pkg::DATA_W-1:0] result_value;

  int mismatch_total;
  int words_awaited;
  int words_checked;
  int full_drops;
  int empty_reads;

  int sent_per_mode [4] = '{0, 0, 0, 0};
  bit no_gaps = 1'b0;
  int idle_cycles = 0;
  int stall_left = 0;
  int quiet_left = 0;
  int stall_roll;

  multi_queue_fifo dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .queue_number (queue_number),
    .data_value   (data_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .result_value (result_value)
  );

  multi_queue_fifo_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .mode           (mode),
    .queue_number   (queue_number),
    .data_value     (data_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .result_value   (result_value),
    .mismatch_total (mismatch_total),
    .words_awaited  (words_awaited),
    .words_checked  (words_checked),
    .full_drops     (full_drops),
    .empty_reads    (empty_reads)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result-side stalls: mostly open, short stalls, rare long ones, and
  // occasional quiet windows with no stall at all.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (quiet_left > 0) begin
      quiet_left = quiet_left - 1;
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 999);
      if (stall_roll < 5) begin
        quiet_left = $urandom_range(50, 300);
        rsp_stall <= 1'b0;
      end else if (stall_roll < 700) begin
        rsp_stall <= 1'b0;
      end else if (stall_roll < 980) begin
        stall_left = $urandom_range(0, 2);
        rsp_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(8, 40);
        rsp_stall <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("multi_queue_fifo regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap length before the next request word: mostly none, some short, few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Data values lean on the extremes now and then.
  function automatic logic signed [mqf_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(0, 39))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Presents one request word, holds it until taken, then maybe idles.
  task automatic send_word(input logic        [mqf_pkg::MODE_W-1:0] m,
                           input logic        [mqf_pkg::QNUM_W-1:0] q,
                           input logic signed [mqf_pkg::DATA_W-1:0] d);
    int gap;
    req_valid    <= 1'b1;
    mode         <= m;
    queue_number <= q;
    data_value   <= d;
    do @(posedge clk); while (req_stall);
    sent_per_mode[m]++;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One phase of random traffic, around a hot queue or as noise on all queues.
  task automatic run_phase();
    int                           flavor;
    int                           roll;
    int                           enq_pct;
    logic [mqf_pkg::QNUM_W-1:0]   hot_queue;
    logic [mqf_pkg::QNUM_W-1:0]   q;
    logic [mqf_pkg::MODE_W-1:0]   m;
    flavor    = $urandom_range(0, 3);
    hot_queue = mqf_pkg::QNUM_W'($urandom_range(0, mqf_pkg::NUM_QUEUES - 1));
    no_gaps   = ($urandom_range(0, 4) == 0);
    enq_pct   = (flavor == 0) ? 70 : (flavor == 1) ? 20 : 45;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (flavor == 3) begin
        // Noise: any code, any queue.
        m = mqf_pkg::MODE_W'($urandom_range(0, 3));
        q = mqf_pkg::QNUM_W'($urandom_range(0, mqf_pkg::NUM_QUEUES - 1));
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          q = hot_queue;
        end else begin
          q = mqf_pkg::QNUM_W'($urandom_range(0, mqf_pkg::NUM_QUEUES - 1));
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) m = MODE_RSVD;
        else if (roll < 10) m = mqf_pkg::MODE_EMPTY;
        else if (roll < 10 + (enq_pct * 90) / 100) m = mqf_pkg::MODE_ENQ;
        else m = mqf_pkg::MODE_DEQ;
      end
      send_word(m, q, pick_data());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, extreme values in order, reserved code.
    send_word(mqf_pkg::MODE_EMPTY, 3'd0, 32'sh0);
    send_word(mqf_pkg::MODE_DEQ,   3'd0, 32'sh1234_5678);
    send_word(mqf_pkg::MODE_ENQ,   3'd0, 32'sh7fff_ffff);
    send_word(mqf_pkg::MODE_ENQ,   3'd0, 32'sh8000_0000);
    send_word(mqf_pkg::MODE_EMPTY, 3'd0, 32'sh0);
    send_word(mqf_pkg::MODE_DEQ,   3'd0, 32'sh0);
    send_word(mqf_pkg::MODE_DEQ,   3'd0, 32'sh0);
    send_word(MODE_RSVD,           3'd7, 32'shffff_ffff);

    // Directed: fill one queue to the brim, then overflow it.
    for (int i = 0; i < mqf_pkg::QUEUE_DEPTH; i++) begin
      send_word(mqf_pkg::MODE_ENQ, 3'd5, $urandom);
    end
    send_word(mqf_pkg::MODE_ENQ,   3'd5, 32'sh5555_aaaa);
    send_word(mqf_pkg::MODE_EMPTY, 3'd5, 32'sh0);

    // Random traffic.
    for (int p = 0; p < RANDOM_PHASES; p++) run_phase();
    req_valid <= 1'b0;

    // The checker's outstanding count is registered, so let it settle
    // before waiting for the drain.
    @(posedge clk);
    while (words_awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d enqueue, %0d dequeue, %0d empty-query and %0d reserved words.",
             sent_per_mode[mqf_pkg::MODE_ENQ], sent_per_mode[mqf_pkg::MODE_DEQ],
             sent_per_mode[mqf_pkg::MODE_EMPTY], sent_per_mode[MODE_RSVD]);
    $display("Checked %0d result words, %0d full drops, %0d dequeues from empty queues.",
             words_checked, full_drops, empty_reads);
    if (mismatch_total == 0 && words_awaited == 0) begin
      $display("multi_queue_fifo regression: pass");
    end else begin
      $display("multi_queue_fifo regression: fail");
    end
    $finish;
  end

endmodule
